// File: rtl/reno_congestion_window_macros.svh
// ----------------------------------------------------------------------------
// reno congestion window assertion macros
// shared concurrent assertion forms, clocked on clock and quiet in reset
// ----------------------------------------------------------------------------
`ifndef RENO_CONGESTION_WINDOW_MACROS_SVH
`define RENO_CONGESTION_WINDOW_MACROS_SVH

// same-cycle implication
`define RCW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcw check failed");

// next-cycle implication
`define RCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcw check failed");

`endif

// File: rtl/rcw_pkg.sv
// ----------------------------------------------------------------------------
// rcw_pkg
// shared types and reset constants of the reno congestion window engine
// ----------------------------------------------------------------------------
package rcw_pkg;

   localparam int RSP_BITS = 32;
   localparam int SEG_BITS = 16;

   // register reset values
   localparam logic [SEG_BITS-1:0] RST_SEGMENT_SIZE      = 16'd1350;
   localparam logic [31:0]         RST_INITIAL_THRESHOLD = 32'd1350;
   localparam logic [31:0]         RST_INITIAL_WINDOW    = 32'd2700;
   localparam logic [31:0]         RST_PACING_VALUE      = 32'd123456789;

   // register indexes
   localparam logic [1:0] CSR_SEGMENT_SIZE      = 2'd0;
   localparam logic [1:0] CSR_INITIAL_THRESHOLD = 2'd1;
   localparam logic [1:0] CSR_INITIAL_WINDOW    = 2'd2;
   localparam logic [1:0] CSR_PACING_VALUE      = 2'd3;

   typedef enum logic [1:0] {
      ACT_FINISHED = 2'd0,
      ACT_DROPPED  = 2'd1,
      ACT_OTHER    = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      PH_SLOW_START = 2'b01,
      PH_AVOIDANCE  = 2'b10
   } phase_type;

   typedef struct packed {
      logic [SEG_BITS-1:0] segment_size;
      logic [31:0]         pacing_value;
   } cfg_type;

   typedef struct packed {
      logic [RSP_BITS-1:0] window_out;
      logic [RSP_BITS-1:0] threshold_out;
      logic                phase_out;
      logic [31:0]         send_rate;
      logic                batch_end;
   } rsp_type;

endpackage

// File: rtl/reno_congestion_window.sv
// ----------------------------------------------------------------------------
// reno_congestion_window: reno congestion window engine, one result per event
// result: registered, and valid in the cycle after its event beat is accepted
// throughput: one event per cycle while rsp_ready holds; stalls on the result side set the pace
// reset: window 2700, threshold 1350, slow start, registers to defaults
// ----------------------------------------------------------------------------
module reno_congestion_window import rcw_pkg::*; #(
   parameter int WINDOW_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // event channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic        req_last_in_batch,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_window_out,
   output logic [31:0] rsp_threshold_out,
   output logic        rsp_phase_out,
   output logic [31:0] rsp_send_rate,
   output logic        rsp_batch_end,
   // configuration write port
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_data;
   logic    accept;

   // an event beat is taken whenever the result register is empty or drains
   assign accept = req_valid && req_ready;

   // segment size and pacing value; the initial window and threshold are
   // reset constants in practice since reset also restores those registers
   rcw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // state update: saturating ack count, doubling in slow start, one segment
   // per window in avoidance, halving with a one-segment floor on a drop; result is the new state
   rcw_core #(
      .WINDOW_BITS (WINDOW_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .action        (req_action),
      .last_in_batch (req_last_in_batch),
      .cfg           (cfg),
      .result        (result)
   );

   // result register parts the two channels; ready only looks downstream
   rcw_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .result    (result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .req_ready (req_ready)
   );

   // window and threshold report the low 32 bits of the state
   assign rsp_window_out    = rsp_data.window_out;
   assign rsp_threshold_out = rsp_data.threshold_out;
   assign rsp_phase_out     = rsp_data.phase_out;
   assign rsp_send_rate     = rsp_data.send_rate;
   assign rsp_batch_end     = rsp_data.batch_end;

endmodule

// File: rtl/rcw_csr.sv
// ----------------------------------------------------------------------------
// rcw_csr
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module rcw_csr import rcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output cfg_type     cfg
);

   logic [SEG_BITS-1:0] segment_size_ff, segment_size_in;
   logic [31:0]         pacing_value_ff, pacing_value_in;

   // initial threshold and window only matter at reset, and reset restores
   // their defaults as well, so writes to them leave nothing to store
   always_comb begin
      segment_size_in = segment_size_ff;
      pacing_value_in = pacing_value_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SEGMENT_SIZE:      segment_size_in = csr_write_data[SEG_BITS-1:0];
            CSR_INITIAL_THRESHOLD: ;
            CSR_INITIAL_WINDOW:    ;
            CSR_PACING_VALUE:      pacing_value_in = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segment_size_ff <= RST_SEGMENT_SIZE;
         pacing_value_ff <= RST_PACING_VALUE;
      end else begin
         segment_size_ff <= segment_size_in;
         pacing_value_ff <= pacing_value_in;
      end
   end

   assign cfg.segment_size = segment_size_ff;
   assign cfg.pacing_value = pacing_value_ff;

endmodule

// File: rtl/rcw_core.sv
// ----------------------------------------------------------------------------
// rcw_core
// window, threshold, acked-byte and phase state with its one-beat update
// ----------------------------------------------------------------------------
module rcw_core import rcw_pkg::*; #(
   parameter int WINDOW_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] action,
   input  logic       last_in_batch,
   input  cfg_type    cfg,
   output rsp_type    result
);

   localparam int W = WINDOW_BITS;

   logic [W-1:0] window_ff, window_in;
   logic [W-1:0] threshold_ff, threshold_in;
   logic [W-1:0] acked_ff, acked_in;
   phase_type    phase_ff, phase_in;

   logic [W-1:0] seg_w;
   logic [W:0]   ack_sum;
   logic [W-1:0] ack_sat;
   logic [W:0]   win_sum;
   logic [W-1:0] win_sat;
   logic [W-1:0] win_dbl;
   logic [W-1:0] half;
   logic [W-1:0] drop_thr;
   logic         ack_full;

   assign seg_w    = W'(cfg.segment_size);
   assign ack_sum  = {1'b0, acked_ff} + {1'b0, seg_w};
   assign ack_sat  = ack_sum[W] ? '1 : ack_sum[W-1:0];
   assign ack_full = ack_sat >= window_ff;
   assign win_sum  = {1'b0, window_ff} + {1'b0, seg_w};
   assign win_sat  = win_sum[W] ? '1 : win_sum[W-1:0];
   assign win_dbl  = window_ff[W-1] ? '1 : {window_ff[W-2:0], 1'b0};
   assign half     = window_ff >> 1;
   assign drop_thr = (half > seg_w) ? half : seg_w;

   always_comb begin
      window_in    = window_ff;
      threshold_in = threshold_ff;
      acked_in     = acked_ff;
      phase_in     = phase_ff;
      unique case (action_type'(action))
         ACT_FINISHED: begin
            acked_in = ack_sat;
            if (phase_ff == PH_SLOW_START) begin
               if (ack_full) begin
                  window_in = win_dbl;
                  acked_in  = '0;
               end
               if (window_in >= threshold_ff) phase_in = PH_AVOIDANCE;
            end else begin
               if (ack_full) begin
                  window_in = win_sat;
                  acked_in  = '0;
               end
            end
         end
         ACT_DROPPED: begin
            acked_in     = '0;
            threshold_in = drop_thr;
            window_in    = drop_thr;
            phase_in     = PH_AVOIDANCE;
         end
         default: ;  // other events and the unused code keep the state
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= W'(RST_INITIAL_WINDOW);
         threshold_ff <= W'(RST_INITIAL_THRESHOLD);
         acked_ff     <= '0;
         phase_ff     <= PH_SLOW_START;
      end else if (accept) begin
         window_ff    <= window_in;
         threshold_ff <= threshold_in;
         acked_ff     <= acked_in;
         phase_ff     <= phase_in;
      end
   end

   assign result.window_out    = RSP_BITS'(window_in);
   assign result.threshold_out = RSP_BITS'(threshold_in);
   assign result.phase_out     = (phase_in == PH_AVOIDANCE);
   assign result.send_rate     = cfg.pacing_value;
   assign result.batch_end     = last_in_batch;

endmodule

// File: rtl/rcw_out_reg.sv
// ----------------------------------------------------------------------------
// rcw_out_reg
// result register; refills in the beat it drains so, while rsp_ready holds, events flow every cycle
// ----------------------------------------------------------------------------
module rcw_out_reg import rcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  rsp_type result,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    req_ready
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign req_ready = !valid_ff || rsp_ready;
   assign valid_in  = accept || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: rtl/rcw_checker.sv
// ----------------------------------------------------------------------------
// rcw_checker
// port-level checks on the reno congestion window engine, bound to the top
// ----------------------------------------------------------------------------
`include "reno_congestion_window_macros.svh"

module rcw_checker import rcw_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_action,
   input logic        req_last_in_batch,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_window_out,
   input logic [31:0] rsp_threshold_out,
   input logic        rsp_phase_out,
   input logic [31:0] rsp_send_rate,
   input logic        rsp_batch_end
);

   // a stalled result holds
   `RCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_window_out) && $stable(rsp_threshold_out) &&
      $stable(rsp_phase_out) && $stable(rsp_send_rate) && $stable(rsp_batch_end))

   // no new event while the result register is stuck
   `RCW_ASSERT_NOW(a_no_overrun, rsp_valid && !rsp_ready, !req_ready)

   // every accepted event gives a result in the next cycle with its batch mark
   `RCW_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready,
      rsp_valid && rsp_batch_end == $past(req_last_in_batch))

   // a drop lands window on threshold in avoidance
   `RCW_ASSERT_NEXT(a_drop_result, req_valid && req_ready && req_action == ACT_DROPPED,
      rsp_window_out == rsp_threshold_out && rsp_phase_out)

endmodule

bind reno_congestion_window rcw_checker u_rcw_checker (.*);

// File: verif/reno_window_checker.sv
// ----------------------------------------------------------------------------
// reno_window_checker
// watches the event, result and register ports of the congestion window
// engine, predicts every result beat and compares it field by field
// ----------------------------------------------------------------------------
module reno_window_checker import rcw_pkg::*; #(
   parameter int WINDOW_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic        req_last_in_batch,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_window_out,
   input  logic [31:0] rsp_threshold_out,
   input  logic        rsp_phase_out,
   input  logic [31:0] rsp_send_rate,
   input  logic        rsp_batch_end,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic PHASE_SLOW_START = 1'b0;
   localparam logic PHASE_AVOIDANCE  = 1'b1;
   localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = '1;

   // register copies; the initial ones are stored but never used, since reset restores the defaults
   logic [SEG_BITS-1:0]    seg_bytes;
   logic [31:0]            init_threshold;
   logic [31:0]            init_window;
   logic [31:0]            pacing;

   // predicted engine state
   logic [WINDOW_BITS-1:0] cwnd;
   logic [WINDOW_BITS-1:0] ssthresh;
   logic [WINDOW_BITS-1:0] acked;
   logic                   phase;

   rsp_type                expected_q[$];
   rsp_type                due;
   rsp_type                seen;

   function automatic logic [WINDOW_BITS-1:0] sat_add(input logic [WINDOW_BITS-1:0] a,
                                                      input logic [WINDOW_BITS-1:0] b);
      logic [WINDOW_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[WINDOW_BITS] ? WINDOW_MAX : sum[WINDOW_BITS-1:0];
   endfunction

   function automatic logic [WINDOW_BITS-1:0] sat_double(input logic [WINDOW_BITS-1:0] a);
      return a[WINDOW_BITS-1] ? WINDOW_MAX : (a << 1);
   endfunction

   task automatic apply_event(input logic [1:0] act);
      logic [WINDOW_BITS-1:0] seg;
      logic [WINDOW_BITS-1:0] half;
      seg  = WINDOW_BITS'(seg_bytes);
      half = cwnd >> 1;
      if (act == ACT_FINISHED) begin
         acked = sat_add(acked, seg);
         if (phase == PHASE_SLOW_START) begin
            if (acked >= cwnd) begin
               cwnd  = sat_double(cwnd);
               acked = '0;
            end
            if (cwnd >= ssthresh) phase = PHASE_AVOIDANCE;
         end else if (acked >= cwnd) begin
            cwnd  = sat_add(cwnd, seg);
            acked = '0;
         end
      end else if (act == ACT_DROPPED) begin
         acked    = '0;
         ssthresh = (half > seg) ? half : seg;
         cwnd     = ssthresh;
         phase    = PHASE_AVOIDANCE;
      end
      // other codes leave the state alone
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seg_bytes      = RST_SEGMENT_SIZE;
         init_threshold = RST_INITIAL_THRESHOLD;
         init_window    = RST_INITIAL_WINDOW;
         pacing         = RST_PACING_VALUE;
         cwnd           = WINDOW_BITS'(RST_INITIAL_WINDOW);
         ssthresh       = WINDOW_BITS'(RST_INITIAL_THRESHOLD);
         acked          = '0;
         phase          = PHASE_SLOW_START;
         expected_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_window_out, rsp_threshold_out, rsp_phase_out,
                     rsp_send_rate, rsp_batch_end};
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t unexpected result beat: win %0d thr %0d ph %0d",
                           $realtime, seen.window_out, seen.threshold_out,
                           seen.phase_out);
            end else begin
               due = expected_q.pop_front();
               if (seen.window_out !== due.window_out ||
                   seen.threshold_out !== due.threshold_out ||
                   seen.phase_out !== due.phase_out ||
                   seen.send_rate !== due.send_rate ||
                   seen.batch_end !== due.batch_end) begin
                  mismatch_count++;
                  // fields in order: window, threshold, phase, rate, batch end
                  if (mismatch_count <= 10)
                     $display("%0t mismatch: exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                              $realtime, due.window_out, due.threshold_out,
                              due.phase_out, due.send_rate, due.batch_end,
                              seen.window_out, seen.threshold_out, seen.phase_out,
                              seen.send_rate, seen.batch_end);
               end
            end
         end
         if (req_valid && req_ready) begin
            apply_event(req_action);
            expected_q.push_back('{32'(cwnd), 32'(ssthresh), phase, pacing,
                                   req_last_in_batch});
         end
         // register writes act from the next event on
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SEGMENT_SIZE:      seg_bytes      = csr_write_data[SEG_BITS-1:0];
               CSR_INITIAL_THRESHOLD: init_threshold = csr_write_data;
               CSR_INITIAL_WINDOW:    init_window    = csr_write_data;
               CSR_PACING_VALUE:      pacing         = csr_write_data;
               default: ;
            endcase
         end
      end
      pending_results = expected_q.size();
   end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives transport events into the reno congestion window engine in random
// bursts, stalls the result side, steps through several register settings
// and takes the verdict from the companion checker
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcw_pkg::*;

   // the spare action code, ignored by the engine like ACT_OTHER
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_EVENTS = 1900;
   localparam int RANDOM_PHASES = 7;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic        req_last_in_batch;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_window_out;
   logic [31:0] rsp_threshold_out;
   logic        rsp_phase_out;
   logic [31:0] rsp_send_rate;
   logic        rsp_batch_end;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;

   int mismatch_count;
   int pending_results;

   // stimulus bookkeeping for the closing summary
   int ack_beats;
   int drop_beats;
   int ignored_beats;
   int csr_writes;

   reno_congestion_window dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_window_out    (rsp_window_out),
      .rsp_threshold_out (rsp_threshold_out),
      .rsp_phase_out     (rsp_phase_out),
      .rsp_send_rate     (rsp_send_rate),
      .rsp_batch_end     (rsp_batch_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   reno_window_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_window_out    (rsp_window_out),
      .rsp_threshold_out (rsp_threshold_out),
      .rsp_phase_out     (rsp_phase_out),
      .rsp_send_rate     (rsp_send_rate),
      .rsp_batch_end     (rsp_batch_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pending_results   (pending_results)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: errors");
      $finish;
   end

   // result side back-pressure: a new stall mode after each random span
   initial begin
      int mode;
      int span;
      int tick;
      rsp_ready = 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(3);
         span = $urandom_range(20, 60);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               0:       rsp_ready = 1'b1;                        // no stalls
               1:       rsp_ready = 1'($urandom_range(1));       // coin flip
               2:       rsp_ready = ($urandom_range(3) == 0);    // mostly stalled
               default: rsp_ready = (tick % 5 == 0);             // periodic
            endcase
         end
      end
   end

   // one event beat; valid stays high on return so the next beat can follow
   // without a bubble, the caller drops it when a gap starts
   task automatic send_event(input logic [1:0] act, input logic last);
      req_valid         = 1'b1;
      req_action        = act;
      req_last_in_batch = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (act == ACT_FINISHED)     ack_beats++;
      else if (act == ACT_DROPPED) drop_beats++;
      else                         ignored_beats++;
   endtask

   // sender gap, payload wanders while valid is low
   task automatic sender_gap(input int cycles);
      req_valid = 1'b0;
      repeat (cycles) begin
         req_action        = 2'($urandom);
         req_last_in_batch = 1'($urandom);
         @(negedge clock);
      end
   endtask

   // hold off until every result is back
   task automatic drain_results;
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      csr_writes++;
   endtask

   // event mix with a tunable drop share, spare codes included
   function automatic logic [1:0] pick_action(input int drop_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < drop_pct)           return ACT_DROPPED;
      else if (roll < drop_pct + 7)  return ACT_OTHER;
      else if (roll < drop_pct + 11) return ACT_UNUSED;
      else                           return ACT_FINISHED;
   endfunction

   // bursts of random length with random gaps until enough events went in
   task automatic event_bursts(input int target, input int drop_pct);
      int counted;
      int burst;
      logic [1:0] act;
      counted = 0;
      while (counted < target) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            act = pick_action(drop_pct);
            send_event(act, 1'($urandom_range(1)));
            counted++;
         end
         if ($urandom_range(3) != 0)
            sender_gap($urandom_range(1, ($urandom_range(3) == 0) ? 15 : 4));
      end
   endtask

   initial begin
      logic [15:0] seg;
      logic [31:0] pace;
      int          drop_pct;
      int          per_phase;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_FINISHED;
      req_last_in_batch = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_SEGMENT_SIZE;
      csr_write_data    = '0;
      ack_beats         = 0;
      drop_beats        = 0;
      ignored_beats     = 0;
      csr_writes        = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values: first ack leaves slow start since the window is
      // already above the threshold, then growth, ignored codes and a drop
      send_event(ACT_FINISHED, 1'b0);
      send_event(ACT_FINISHED, 1'b1);
      send_event(ACT_OTHER, 1'b0);
      send_event(ACT_UNUSED, 1'b1);
      send_event(ACT_FINISHED, 1'b0);
      send_event(ACT_DROPPED, 1'b1);

      // zero segment: repeated drops halve the window down to zero, then
      // acks on a zero window match the counter test and keep it at zero
      drain_results;
      write_csr(CSR_SEGMENT_SIZE, 32'hFFFF_0000);
      write_csr(CSR_PACING_VALUE, 32'h0000_0000);
      write_csr(CSR_INITIAL_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(CSR_INITIAL_WINDOW, 32'h0000_0001);
      repeat (12) send_event(ACT_DROPPED, 1'($urandom_range(1)));
      send_event(ACT_FINISHED, 1'b0);
      send_event(ACT_FINISHED, 1'b1);

      // largest segment: the window climbs out of zero in big steps,
      // then a drop where half the window equals the segment
      drain_results;
      write_csr(CSR_SEGMENT_SIZE, 32'h0000_FFFF);
      write_csr(CSR_PACING_VALUE, 32'hFFFF_FFFF);
      write_csr(CSR_INITIAL_THRESHOLD, 32'h0000_0001);
      write_csr(CSR_INITIAL_WINDOW, 32'hFFFF_FFFF);
      send_event(ACT_FINISHED, 1'b0);
      send_event(ACT_FINISHED, 1'b1);
      send_event(ACT_FINISHED, 1'b0);
      send_event(ACT_DROPPED, 1'b1);

      // random part, one register setting per phase
      per_phase = RANDOM_EVENTS / RANDOM_PHASES;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin seg = 16'd1;        pace = $urandom;         drop_pct = 5;  end
            1: begin seg = 16'($urandom); pace = $urandom;        drop_pct = 15; end
            2: begin seg = RST_SEGMENT_SIZE; pace = RST_PACING_VALUE; drop_pct = 10; end
            3: begin seg = 16'hFFFF;     pace = 32'hFFFF_FFFF;    drop_pct = 3;  end
            4: begin seg = 16'($urandom_range(1, 200)); pace = $urandom; drop_pct = 2; end
            5: begin seg = 16'd0;        pace = 32'h0000_0000;    drop_pct = 10; end
            default: begin seg = 16'($urandom); pace = $urandom;  drop_pct = 8;  end
         endcase
         // every phase boundary is also a pause until all results are back
         drain_results;
         write_csr(CSR_SEGMENT_SIZE, {16'($urandom), seg});
         write_csr(CSR_PACING_VALUE, pace);
         if ($urandom_range(1)) write_csr(CSR_INITIAL_THRESHOLD, $urandom);
         if ($urandom_range(1)) write_csr(CSR_INITIAL_WINDOW, $urandom);
         event_bursts(per_phase, drop_pct);
      end

      // let the last results out, then the verdict
      drain_results;
      repeat (3) @(negedge clock);
      $display("summary: %0d ack, %0d drop and %0d ignored event beats",
               ack_beats, drop_beats, ignored_beats);
      $display("summary: %0d register writes across %0d settings",
               csr_writes, RANDOM_PHASES + 3);
      if (mismatch_count == 0 && pending_results == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rcw_pkg.sv
rtl/rcw_csr.sv
rtl/rcw_core.sv
rtl/rcw_out_reg.sv
rtl/reno_congestion_window.sv
rtl/rcw_checker.sv
verif/reno_window_checker.sv
verif/tb.sv
